>>> rtl/core/rthsv_pkg.sv
package rthsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 12;

    // hue divisor is 6*delta, which needs three bits above a channel
    localparam int HDIV_BITS = CHANNEL_BITS + 3;

    // one restoring division step per cell, the longer quotient sets the row length
    localparam int CHAIN_LEN = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] value;
    } t_hsv;

    // operands handed from the front stage to the divider row
    typedef struct packed {
        logic [HDIV_BITS-1:0]    hue_num;
        logic [HDIV_BITS-1:0]    hue_div;
        logic [CHANNEL_BITS-1:0] sat_hi;
        logic [CHANNEL_BITS-1:0] sat_lo;
        logic [CHANNEL_BITS-1:0] sat_div;
        logic                    gray;
        logic                    black;
        logic [CHANNEL_BITS-1:0] value;
    } t_front;

endpackage

>>> rtl/core/rthsv_front.sv
module rthsv_front
    import rthsv_pkg::*;
(
    input  logic   i_clk,
    input  t_rgb   i_pixel,
    output t_front o_front
);

    logic [CHANNEL_BITS-1:0]   mx;
    logic [CHANNEL_BITS-1:0]   mn;
    logic [CHANNEL_BITS-1:0]   delta;
    logic [HDIV_BITS-1:0]      d_ext;
    logic [HDIV_BITS-1:0]      six;
    logic [HDIV_BITS-1:0]      r_ext;
    logic [HDIV_BITS-1:0]      g_ext;
    logic [HDIV_BITS-1:0]      b_ext;
    logic [HDIV_BITS-1:0]      num;
    logic [2*CHANNEL_BITS-1:0] sat_n;
    t_front                    n_front;
    t_front                    r_front;

    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue  > mx) mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue  < mn) mn = i_pixel.blue;
        delta = mx - mn;

        d_ext = HDIV_BITS'(delta);
        r_ext = HDIV_BITS'(i_pixel.red);
        g_ext = HDIV_BITS'(i_pixel.green);
        b_ext = HDIV_BITS'(i_pixel.blue);
        six   = (d_ext << 2) + (d_ext << 1);

        // sector offset, red wins ties, then green; sums are never negative
        priority if (mx == i_pixel.red) begin
            num = (g_ext >= b_ext) ? (g_ext - b_ext) : (six - (b_ext - g_ext));
        end else if (mx == i_pixel.green) begin
            num = (d_ext << 1) + b_ext - r_ext;
        end else begin
            num = (d_ext << 2) + r_ext - g_ext;
        end

        // (2^n - 1) * delta
        sat_n = ((2*CHANNEL_BITS)'(delta) << CHANNEL_BITS) - (2*CHANNEL_BITS)'(delta);

        n_front.hue_num = num;
        n_front.hue_div = six;
        n_front.sat_hi  = sat_n[2*CHANNEL_BITS-1:CHANNEL_BITS];
        n_front.sat_lo  = sat_n[CHANNEL_BITS-1:0];
        n_front.sat_div = mx;
        n_front.gray    = (delta == '0);
        n_front.black   = (mx == '0);
        n_front.value   = mx;
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign o_front = r_front;

endmodule

>>> rtl/core/rthsv_div_cell.sv
module rthsv_div_cell #(
    parameter int DIV_W   = 8,
    parameter int LOW_W   = 8,
    parameter int QUO_W   = 8,
    parameter bit STEP_EN = 1'b1
) (
    input  logic             i_clk,
    input  logic [DIV_W-1:0] i_rem,
    input  logic [DIV_W-1:0] i_div,
    input  logic [LOW_W-1:0] i_low,
    input  logic [QUO_W-1:0] i_quo,
    output logic [DIV_W-1:0] o_rem,
    output logic [DIV_W-1:0] o_div,
    output logic [LOW_W-1:0] o_low,
    output logic [QUO_W-1:0] o_quo
);

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] n_rem;
    logic [LOW_W-1:0] n_low;
    logic [QUO_W-1:0] n_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [LOW_W-1:0] r_low;
    logic [QUO_W-1:0] r_quo;

    always_comb begin
        // shift in the next dividend bit, subtract when it fits
        trial = {i_rem, i_low[LOW_W-1]};
        diff  = trial - {1'b0, i_div};
        ge    = (trial >= {1'b0, i_div});
        if (STEP_EN) begin
            n_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            n_low = i_low << 1;
            n_quo = {i_quo[QUO_W-2:0], ge};
        end else begin
            n_rem = i_rem;
            n_low = i_low;
            n_quo = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= i_div;
        r_low <= n_low;
        r_quo <= n_quo;
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_low = r_low;
    assign o_quo = r_quo;

endmodule

>>> rtl/core/rgb_to_hsv_pixel_converter.sv
// rgb to hsv pixel converter
//
// input channel: one rgb pixel on i_pixel, taken at a rising edge where start
// is high and busy is low; busy stays low, so an item may enter every cycle
// output channel: o_result holds hue, saturation and value for exactly one
// cycle while o_strobe is high; the receiver cannot stall and need not
// one front stage for max, min, sector and operands feeds a restoring divider
// row with one cell per quotient bit
// throughput: one item per cycle, set by the row of division cells where
// every cell works on a different item in each cycle
// results leave in the order their items were taken
// reset clears the valid pipe only, so no strobe comes from items that were
// in flight; there is no other state between items
module rgb_to_hsv_pixel_converter
    import rthsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_rgb i_pixel,
    output logic o_strobe,
    output t_hsv o_result
);

    localparam int LAT = CHAIN_LEN + 1;

    t_front front;

    // row taps, index 0 feeds the first cell
    logic [HDIV_BITS-1:0]    w_hrem [0:CHAIN_LEN];
    logic [HDIV_BITS-1:0]    w_hdiv [0:CHAIN_LEN];
    logic                    w_hlow [0:CHAIN_LEN];
    logic [HUE_BITS-1:0]     w_hquo [0:CHAIN_LEN];
    logic [CHANNEL_BITS-1:0] w_srem [0:CHAIN_LEN];
    logic [CHANNEL_BITS-1:0] w_sdiv [0:CHAIN_LEN];
    logic [CHANNEL_BITS-1:0] w_slow [0:CHAIN_LEN];
    logic [CHANNEL_BITS-1:0] w_squo [0:CHAIN_LEN];

    // valid bits: bit 0 is the front stage, bit i+1 the output of cell i
    logic [CHAIN_LEN:0]      r_vld;
    logic [CHAIN_LEN:0]      n_vld;
    // gray/black flags and value ride next to the cells
    logic                    r_gray  [1:CHAIN_LEN];
    logic                    r_black [1:CHAIN_LEN];
    logic [CHANNEL_BITS-1:0] r_value [1:CHAIN_LEN];

    assign busy = 1'b0;

    rthsv_front u_front (
        .i_clk   (i_clk),
        .i_pixel (i_pixel),
        .o_front (front)
    );

    assign w_hrem[0] = front.hue_num;
    assign w_hdiv[0] = front.hue_div;
    assign w_hlow[0] = 1'b0;
    assign w_hquo[0] = '0;
    assign w_srem[0] = front.sat_hi;
    assign w_sdiv[0] = front.sat_div;
    assign w_slow[0] = front.sat_lo;
    assign w_squo[0] = '0;

    for (genvar gi = 0; gi < CHAIN_LEN; gi++) begin : g_row
        // hue: remainder starts below the divisor, zeros shift in
        rthsv_div_cell #(
            .DIV_W   (HDIV_BITS),
            .LOW_W   (1),
            .QUO_W   (HUE_BITS),
            .STEP_EN (gi < HUE_BITS)
        ) u_hue_cell (
            .i_clk (i_clk),
            .i_rem (w_hrem[gi]),
            .i_div (w_hdiv[gi]),
            .i_low (w_hlow[gi]),
            .i_quo (w_hquo[gi]),
            .o_rem (w_hrem[gi+1]),
            .o_div (w_hdiv[gi+1]),
            .o_low (w_hlow[gi+1]),
            .o_quo (w_hquo[gi+1])
        );

        // saturation: upper half of the product is below max, lower half shifts in
        rthsv_div_cell #(
            .DIV_W   (CHANNEL_BITS),
            .LOW_W   (CHANNEL_BITS),
            .QUO_W   (CHANNEL_BITS),
            .STEP_EN (gi < CHANNEL_BITS)
        ) u_sat_cell (
            .i_clk (i_clk),
            .i_rem (w_srem[gi]),
            .i_div (w_sdiv[gi]),
            .i_low (w_slow[gi]),
            .i_quo (w_squo[gi]),
            .o_rem (w_srem[gi+1]),
            .o_div (w_sdiv[gi+1]),
            .o_low (w_slow[gi+1]),
            .o_quo (w_squo[gi+1])
        );
    end

    always_comb begin
        n_vld = {r_vld[CHAIN_LEN-1:0], start & ~busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gray[1]  <= front.gray;
        r_black[1] <= front.black;
        r_value[1] <= front.value;
        for (int i = 2; i <= CHAIN_LEN; i++) begin
            r_gray[i]  <= r_gray[i-1];
            r_black[i] <= r_black[i-1];
            r_value[i] <= r_value[i-1];
        end
    end

    // gray pixels divide by zero in the hue row, black ones in the
    // saturation row; both quotients are forced to zero there
    assign o_strobe            = r_vld[CHAIN_LEN];
    assign o_result.hue        = r_gray[CHAIN_LEN]  ? '0 : w_hquo[CHAIN_LEN];
    assign o_result.saturation = r_black[CHAIN_LEN] ? '0 : w_squo[CHAIN_LEN];
    assign o_result.value      = r_value[CHAIN_LEN];

`ifndef SYNTHESIS
    // every strobe goes back to an item that was taken on the input
    a_strobe_has_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching item");

    // a black pixel has neither hue nor saturation
    a_black_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.value == '0) |->
            (o_result.hue == '0 && o_result.saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    // a gray item comes out with zero hue and saturation and its own level
    a_gray_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_pixel.red == i_pixel.green &&
            i_pixel.green == i_pixel.blue) |-> ##LAT
        (o_strobe && o_result.hue == '0 && o_result.saturation == '0 &&
            o_result.value == $past(i_pixel.red, LAT)))
        else $error("gray item converted wrongly");
`endif

endmodule

>>> test/rgb_to_hsv_pixel_converter_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_converter_tb;
    import rthsv_pkg::*;

    // generous bound for ~1750 items and the gaps between bursts
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int DRAIN_CYCLES  = 1 + CHAIN_LEN + 8;
    localparam int MAX_REPORTED  = 10;

    typedef struct {
        t_rgb pixel;
        t_hsv hsv;
    } t_pending_hsv;

    // holds predicted hsv results in arrival order and compares the block against them
    class hsv_scoreboard;
        t_pending_hsv pending_q[$];
        int mismatches;
        int compared;
        int gray_seen;
        int sector_seen[3];

        // exact integer conversion, fractions truncated
        function t_hsv predict_hsv(t_rgb px);
            int unsigned r, g, b, mx, mn, delta, six, num;
            t_hsv res;
            r = px.red;
            g = px.green;
            b = px.blue;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            delta = mx - mn;
            res = '0;
            if (delta == 0) begin
                gray_seen++;
            end else begin
                six = 6 * delta;
                // red wins ties, then green
                if (mx == r) begin
                    num = (g >= b) ? (g - b) : (six - (b - g));
                    sector_seen[0]++;
                end else if (mx == g) begin
                    num = 2 * delta + b - r;
                    sector_seen[1]++;
                end else begin
                    num = 4 * delta + r - g;
                    sector_seen[2]++;
                end
                res.hue = HUE_BITS'((num << HUE_BITS) / six);
            end
            if (mx != 0)
                res.saturation = CHANNEL_BITS'(((2 ** CHANNEL_BITS - 1) * delta) / mx);
            res.value = CHANNEL_BITS'(mx);
            return res;
        endfunction

        function void note_pixel(t_rgb px);
            t_pending_hsv entry;
            entry.pixel = px;
            entry.hsv   = predict_hsv(px);
            pending_q.push_back(entry);
        endfunction

        function void check_result(t_hsv got);
            t_pending_hsv entry;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("[%0t] unexpected result hue=%0d sat=%0d val=%0d",
                             $realtime, got.hue, got.saturation, got.value);
                return;
            end
            entry = pending_q.pop_front();
            compared++;
            if (got.hue !== entry.hsv.hue || got.saturation !== entry.hsv.saturation ||
                got.value !== entry.hsv.value) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display({"[%0t] mismatch rgb=(%0d,%0d,%0d)",
                              " exp h/s/v=%0d/%0d/%0d got %0d/%0d/%0d"},
                             $realtime, entry.pixel.red, entry.pixel.green, entry.pixel.blue,
                             entry.hsv.hue, entry.hsv.saturation, entry.hsv.value,
                             got.hue, got.saturation, got.value);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_rgb i_pixel;
    logic o_strobe;
    t_hsv o_result;

    hsv_scoreboard sb;
    int cycle_count;
    int directed_sent;
    int random_sent;

    rgb_to_hsv_pixel_converter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // results are stable mid-cycle, so the falling edge sidesteps any race with the block
    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            sb.check_result(o_result);
    end

    // hold the pixel until an edge takes it; busy is read at the falling edge before that edge
    task automatic send_pixel(input t_rgb px);
        logic took;
        start   <= 1'b1;
        i_pixel <= px;
        do begin
            @(negedge i_clk);
            took = (busy === 1'b0);
            @(posedge i_clk);
        end while (!took);
        sb.note_pixel(px);
    endtask

    // gap between bursts, junk on the pixel bus that must not be taken
    task automatic pause_sender(input int cycles);
        start   <= 1'b0;
        i_pixel <= t_rgb'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [CHANNEL_BITS-1:0] edge_channel();
        logic [CHANNEL_BITS-1:0] c;
        case ($urandom_range(0, 3))
            0: c = '0;
            1: c = CHANNEL_BITS'(1);
            2: c = '1 - 1'b1;
            default: c = '1;
        endcase
        return c;
    endfunction

    // mix of plain random pixels and shapes that hit ties, grays and small deltas
    function automatic t_rgb random_pixel();
        t_rgb px;
        logic [CHANNEL_BITS-1:0] base, other;
        px    = t_rgb'($urandom);
        base  = CHANNEL_BITS'($urandom);
        other = CHANNEL_BITS'($urandom);
        case ($urandom_range(0, 9))
            // gray, black and white included
            4: px = {base, base, base};
            // two channels tie for the maximum or minimum
            5: begin
                case ($urandom_range(0, 2))
                    0: px = {base, base, other};
                    1: px = {base, other, base};
                    default: px = {other, base, base};
                endcase
            end
            // nearly gray, delta of a few codes
            6: begin
                px.red   = base;
                px.green = (base > 3) ? base - CHANNEL_BITS'($urandom_range(0, 3)) : base;
                px.blue  = (base > 3) ? base - CHANNEL_BITS'($urandom_range(0, 3)) : base;
            end
            7: px = {edge_channel(), edge_channel(), edge_channel()};
            // one channel at full scale
            8: begin
                case ($urandom_range(0, 2))
                    0: px.red = '1;
                    1: px.green = '1;
                    default: px.blue = '1;
                endcase
            end
            // one channel zero
            9: begin
                case ($urandom_range(0, 2))
                    0: px.red = '0;
                    1: px.green = '0;
                    default: px.blue = '0;
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        int burst, gap;
        sb = new();
        cycle_count   = 0;
        directed_sent = 0;
        random_sent   = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_pixel <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: black, white, gray, the primaries and secondaries
        send_pixel({8'd0,   8'd0,   8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd128, 8'd128});
        send_pixel({8'd1,   8'd1,   8'd1});
        send_pixel({8'd255, 8'd0,   8'd0});
        send_pixel({8'd0,   8'd255, 8'd0});
        send_pixel({8'd0,   8'd0,   8'd255});
        send_pixel({8'd255, 8'd255, 8'd0});
        send_pixel({8'd0,   8'd255, 8'd255});
        send_pixel({8'd255, 8'd0,   8'd255});
        // red maximum with blue above green, hue wraps below zero
        send_pixel({8'd255, 8'd0,   8'd1});
        send_pixel({8'd200, 8'd10,  8'd150});
        // ties for the maximum go to the earlier channel
        send_pixel({8'd200, 8'd200, 8'd50});
        send_pixel({8'd200, 8'd50,  8'd200});
        send_pixel({8'd50,  8'd200, 8'd200});
        // smallest nonzero deltas and maxima
        send_pixel({8'd1,   8'd0,   8'd0});
        send_pixel({8'd0,   8'd1,   8'd0});
        send_pixel({8'd0,   8'd0,   8'd1});
        send_pixel({8'd255, 8'd254, 8'd254});
        send_pixel({8'd254, 8'd255, 8'd254});
        send_pixel({8'd254, 8'd254, 8'd255});
        // hue just below a full turn and near sector borders
        send_pixel({8'd255, 8'd0,   8'd254});
        send_pixel({8'd254, 8'd255, 8'd0});
        send_pixel({8'd0,   8'd254, 8'd255});
        send_pixel({8'd170, 8'd85,  8'd0});
        directed_sent = 25;

        // random bursts; some long ones keep the pipe full for a while
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                burst = $urandom_range(40, 120);
            else
                burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && random_sent < RANDOM_ITEMS; i++) begin
                send_pixel(random_pixel());
                random_sent++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                pause_sender(gap);
        end
        pause_sender(1);

        // let the pipe empty, then watch a little longer for stray strobes
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d pixels (%0d directed, %0d random), %0d results compared",
                 directed_sent + random_sent, directed_sent, random_sent, sb.compared);
        $display("gray %0d, red/green/blue sector %0d/%0d/%0d, mismatches %0d, left over %0d",
                 sb.gray_seen, sb.sector_seen[0], sb.sector_seen[1], sb.sector_seen[2],
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
